### design/pmrs_pkg.sv
// Shared types and constants for the power rail sequencer.
package pmrs_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int REG_BITS       = 16;
  localparam int NUM_REGS       = 7;
  localparam int CFG_IDX_BITS   = 3;

  // command codes
  localparam logic [2:0] CMD_TICK      = 3'd0;
  localparam logic [2:0] CMD_POWER_UP  = 3'd1;
  localparam logic [2:0] CMD_POWER_DN  = 3'd2;
  localparam logic [2:0] CMD_RAILS_OFF = 3'd3;
  localparam logic [2:0] CMD_PROG_DONE = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_RAIL_SETTLE   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PROG_SETTLE   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SWITCH_GAP    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_PG_FALL       = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SUPPLY_DISCH  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_PUMP_DISCH    = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_POS_DISCH     = 3'd6;

  // register reset values
  localparam logic [REG_BITS-1:0] RAIL_SETTLE_RST  = 16'd10;
  localparam logic [REG_BITS-1:0] PROG_SETTLE_RST  = 16'd100;
  localparam logic [REG_BITS-1:0] SWITCH_GAP_RST   = 16'd50;
  localparam logic [REG_BITS-1:0] PG_FALL_RST      = 16'd250;
  localparam logic [REG_BITS-1:0] SUPPLY_DISCH_RST = 16'd5000;
  localparam logic [REG_BITS-1:0] PUMP_DISCH_RST   = 16'd5000;
  localparam logic [REG_BITS-1:0] POS_DISCH_RST    = 16'd3000;

  typedef struct packed {
    logic [REG_BITS-1:0] rail_settle_ms;
    logic [REG_BITS-1:0] program_settle_ms;
    logic [REG_BITS-1:0] switch_gap_ms;
    logic [REG_BITS-1:0] pg_fall_timeout_ms;
    logic [REG_BITS-1:0] supply_discharge_ms;
    logic [REG_BITS-1:0] pump_discharge_ms;
    logic [REG_BITS-1:0] positive_discharge_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]          cmd;
    logic                power_good;
    logic [REG_BITS-1:0] pg_rise_timeout_ms;
  } item_t;

  typedef struct packed {
    logic upstream_enable;
    logic chip_enable;
    logic negative_switch_enable;
    logic positive_switch_enable;
    logic pump_switch_enable;
    logic program_request;
    logic busy_res;
    logic powered_up;
    logic sequence_done;
    logic sequence_ok;
    logic power_good_now;
  } result_t;

endpackage

### design/pmrs_fsm.sv
// Sequencer state machine: phase, wait counter and pin levels.
module pmrs_fsm #(
  parameter int COUNT_BITS = pmrs_pkg::COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  pmrs_pkg::item_t  item,
  input  pmrs_pkg::cfg_t   cfg,
  output pmrs_pkg::result_t result
);

  localparam int CMP_BITS = (COUNT_BITS > pmrs_pkg::REG_BITS) ? COUNT_BITS : pmrs_pkg::REG_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  typedef enum logic [3:0] {
    PH_IDLE, PH_RAIL, PH_PROG, PH_PSETTLE, PH_GAPN, PH_GAPP, PH_PGUP,
    PH_PGDN, PH_SUPPLY, PH_PUMP, PH_POS
  } phase_t;

  typedef struct packed {
    logic up;
    logic ce;
    logic neg;
    logic pos;
    logic pump;
  } pins_t;

  phase_t                       phase, phase_next;
  logic [COUNT_BITS-1:0]        wait_count, wait_count_next;
  logic [pmrs_pkg::REG_BITS-1:0] pg_limit, pg_limit_next;
  logic                         upstream_on, upstream_on_next;
  logic                         chip_is_up, chip_is_up_next;
  pins_t                        pin_levels, pin_levels_next;

  logic                          tick;
  logic                          pg;
  logic [COUNT_BITS-1:0]         wait_inc;
  logic [pmrs_pkg::REG_BITS-1:0] lim;
  logic                          timed_over;
  logic                          limit_hit;
  logic                          done;
  logic                          ok;

  assign tick     = (item.cmd == pmrs_pkg::CMD_TICK);
  assign pg       = item.power_good;
  assign wait_inc = (wait_count == CNT_MAX) ? wait_count : wait_count + 1'b1;

  // limit for the current timed wait
  always_comb begin
    case (phase)
      PH_RAIL:    lim = cfg.rail_settle_ms;
      PH_PSETTLE: lim = cfg.program_settle_ms;
      PH_GAPN,
      PH_GAPP:    lim = cfg.switch_gap_ms;
      PH_PGUP:    lim = pg_limit;
      PH_PGDN:    lim = cfg.pg_fall_timeout_ms;
      PH_SUPPLY:  lim = cfg.supply_discharge_ms;
      PH_PUMP:    lim = cfg.pump_discharge_ms;
      PH_POS:     lim = cfg.positive_discharge_ms;
      default:    lim = '0;
    endcase
  end

  assign timed_over = tick && (CMP_BITS'(wait_inc) >= CMP_BITS'(lim));
  assign limit_hit  = CMP_BITS'(wait_count) >= CMP_BITS'(lim);

  always_comb begin
    phase_next       = phase;
    wait_count_next  = wait_count;
    pg_limit_next    = pg_limit;
    upstream_on_next = upstream_on;
    chip_is_up_next  = chip_is_up;
    pin_levels_next  = pin_levels;
    done             = 1'b0;
    ok               = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        if (item.cmd == pmrs_pkg::CMD_POWER_UP) begin
          pg_limit_next   = item.pg_rise_timeout_ms;
          wait_count_next = '0;
          if (!upstream_on) begin
            pin_levels_next.up = 1'b1;
            upstream_on_next   = 1'b1;
            phase_next         = PH_RAIL;
          end else begin
            phase_next = PH_PROG;
          end
        end else if (item.cmd == pmrs_pkg::CMD_POWER_DN) begin
          pin_levels_next.ce = 1'b0;
          wait_count_next    = '0;
          phase_next         = PH_PGDN;
        end else if (item.cmd == pmrs_pkg::CMD_RAILS_OFF) begin
          wait_count_next = '0;
          phase_next      = PH_SUPPLY;
        end
      end
      PH_PROG: begin
        if (item.cmd == pmrs_pkg::CMD_PROG_DONE) begin
          wait_count_next = '0;
          phase_next      = PH_PSETTLE;
        end
      end
      PH_PGUP, PH_PGDN: begin
        if (pg == (phase == PH_PGUP)) begin
          done = 1'b1;
          ok   = 1'b1;
        end else if (tick) begin
          if (limit_hit) begin
            done = 1'b1;
          end else begin
            wait_count_next = wait_inc;
          end
        end
        if (done) begin
          chip_is_up_next = (phase == PH_PGUP) && ok;
          wait_count_next = '0;
          phase_next      = PH_IDLE;
        end
      end
      PH_RAIL, PH_PSETTLE, PH_GAPN, PH_GAPP, PH_SUPPLY, PH_PUMP, PH_POS: begin
        if (tick) begin
          wait_count_next = wait_inc;
        end
        if (timed_over) begin
          wait_count_next = '0;
          case (phase)
            PH_RAIL: phase_next = PH_PROG;
            PH_PSETTLE: begin
              pin_levels_next.neg = 1'b1;
              phase_next          = PH_GAPN;
            end
            PH_GAPN: begin
              pin_levels_next.pos = 1'b1;
              phase_next          = PH_GAPP;
            end
            PH_GAPP: begin
              pin_levels_next.pump = 1'b1;
              pin_levels_next.ce   = 1'b1;
              phase_next           = PH_PGUP;
            end
            PH_SUPPLY: begin
              pin_levels_next.pump = 1'b0;
              phase_next           = PH_PUMP;
            end
            PH_PUMP: begin
              pin_levels_next.pos = 1'b0;
              phase_next          = PH_POS;
            end
            default: begin
              pin_levels_next.neg = 1'b0;
              pin_levels_next.up  = 1'b0;
              upstream_on_next    = 1'b0;
              done                = 1'b1;
              ok                  = 1'b1;
              phase_next          = PH_IDLE;
            end
          endcase
        end
      end
      default: begin
        wait_count_next = '0;
        phase_next      = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      wait_count  <= '0;
      pg_limit    <= '0;
      upstream_on <= 1'b0;
      chip_is_up  <= 1'b0;
      pin_levels  <= '0;
    end else if (step) begin
      phase       <= phase_next;
      wait_count  <= wait_count_next;
      pg_limit    <= pg_limit_next;
      upstream_on <= upstream_on_next;
      chip_is_up  <= chip_is_up_next;
      pin_levels  <= pin_levels_next;
    end
  end

  always_comb begin
    result.upstream_enable        = pin_levels_next.up;
    result.chip_enable            = pin_levels_next.ce;
    result.negative_switch_enable = pin_levels_next.neg;
    result.positive_switch_enable = pin_levels_next.pos;
    result.pump_switch_enable     = pin_levels_next.pump;
    result.program_request        = (phase_next == PH_PROG);
    result.busy_res               = (phase_next != PH_IDLE);
    result.powered_up             = chip_is_up_next;
    result.sequence_done          = done;
    result.sequence_ok            = done && ok;
    result.power_good_now         = pg;
  end

endmodule

### design/pmic_rail_sequencer.sv
// Top level of the display power rail sequencer.
// One transaction is taken per clock while result_ready stays high, and each gives exactly
// one result. A transaction is held in the input register and stepped through the state
// machine when the result register is empty or being read; that edge loads the result
// register. Timed waits advance only on tick transactions, so all delays are counted in
// ticks. Configuration registers are written through cfg_write/cfg_index/cfg_data and
// take effect at once.
module pmic_rail_sequencer #(
  parameter int COUNT_BITS = pmrs_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  pmrs_pkg::item_t                     item,
  output logic                                result_valid,
  input  logic                                result_ready,
  output pmrs_pkg::result_t                   result,
  input  logic                                cfg_write,
  input  logic [pmrs_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [pmrs_pkg::REG_BITS-1:0]       cfg_data
);

  pmrs_pkg::cfg_t    cfg;
  pmrs_pkg::item_t   stage;
  logic              stage_valid;
  logic              advance;
  pmrs_pkg::result_t step_result;

  assign advance    = stage_valid && (!result_valid || result_ready);
  assign item_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rail_settle_ms        <= pmrs_pkg::RAIL_SETTLE_RST;
      cfg.program_settle_ms     <= pmrs_pkg::PROG_SETTLE_RST;
      cfg.switch_gap_ms         <= pmrs_pkg::SWITCH_GAP_RST;
      cfg.pg_fall_timeout_ms    <= pmrs_pkg::PG_FALL_RST;
      cfg.supply_discharge_ms   <= pmrs_pkg::SUPPLY_DISCH_RST;
      cfg.pump_discharge_ms     <= pmrs_pkg::PUMP_DISCH_RST;
      cfg.positive_discharge_ms <= pmrs_pkg::POS_DISCH_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        pmrs_pkg::REG_RAIL_SETTLE:  cfg.rail_settle_ms        <= cfg_data;
        pmrs_pkg::REG_PROG_SETTLE:  cfg.program_settle_ms     <= cfg_data;
        pmrs_pkg::REG_SWITCH_GAP:   cfg.switch_gap_ms         <= cfg_data;
        pmrs_pkg::REG_PG_FALL:      cfg.pg_fall_timeout_ms    <= cfg_data;
        pmrs_pkg::REG_SUPPLY_DISCH: cfg.supply_discharge_ms   <= cfg_data;
        pmrs_pkg::REG_PUMP_DISCH:   cfg.pump_discharge_ms     <= cfg_data;
        pmrs_pkg::REG_POS_DISCH:    cfg.positive_discharge_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      stage <= item;
    end
  end

  pmrs_fsm #(
    .COUNT_BITS(COUNT_BITS)
  ) u_fsm (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .item  (stage),
    .cfg   (cfg),
    .result(step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_result;
    end
  end

  a_ok_needs_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.sequence_ok |-> result.sequence_done)
    else $error("sequence_ok without sequence_done");

  a_prog_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.program_request |-> result.busy_res)
    else $error("program_request while not busy");

  a_switch_order: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!result.pump_switch_enable || result.positive_switch_enable)
                  && (!result.positive_switch_enable || result.negative_switch_enable))
    else $error("supply switches out of order");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !stage_valid)
    else $error("pipeline not empty after reset");

endmodule
